[src/mrs_pkg.sv]
package mrs_pkg;

  // Storage sizes
  localparam int HOLD_WORDS  = 64;
  localparam int FRAME_DEPTH = 64;
  localparam int COIL_BYTES  = 20;
  localparam int REPLY_MAX   = 64;
  localparam int JOBQ_DEPTH  = 2;

  localparam int FRAME_AW = $clog2(FRAME_DEPTH);
  localparam int FLEN_W   = FRAME_AW + 1;
  localparam int HOLD_AW  = $clog2(HOLD_WORDS);
  localparam int COIL_AW  = $clog2(COIL_BYTES);
  localparam int EXP_W    = 9;
  // Coil byte index / bit counter width: covers address span plus a full data field
  localparam int CIDX_W   = 11;
  localparam int KC_W     = CIDX_W;

  // Register map
  localparam logic [15:0] REG_SPAN      = 16'd10000;
  localparam logic [15:0] COIL_MAP_BASE = 16'd100;
  localparam logic [15:0] COIL_MAP_END  = 16'd110;
  localparam logic [15:0] FORCE_LIMIT   = 16'd120;
  localparam logic [15:0] COIL_ON       = 16'hFF00;
  localparam logic [15:0] COIL_OFF      = 16'h0000;

  // Framing
  localparam int FIXED_LEN  = 8;
  localparam int LEN_EXTRA  = 9;
  localparam int FIRST_DATA = 7;
  localparam int MAX_BC     = REPLY_MAX - 5;
  localparam int MAX_WORDS  = (REPLY_MAX - 5) / 2;

  // CRC
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes
  localparam logic [7:0] FC_READ_COILS  = 8'h01;
  localparam logic [7:0] FC_READ_INPUTS = 8'h02;
  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_READ_INREG  = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FC_WRITE_REG   = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS  = 8'h10;

  // Config register indexes
  localparam logic CFG_SLAVE_ADDR  = 1'b0;
  localparam logic CFG_FAULT_LIMIT = 1'b1;

  // Header byte positions
  localparam logic [2:0] HDR_LAST_READ = 3'd2;
  localparam logic [2:0] HDR_LAST_ECHO = 3'd5;

  typedef struct packed {
    logic              tick;
    logic              fault;
    logic [FLEN_W-1:0] flen;
  } job_t;

  typedef enum logic [4:0] {
    S_IDLE, S_STAT, S_CRC, S_CHECK, S_MOD, S_DISP,
    S_W5, S_WW1, S_WW2, S_M10_RD, S_M10_HI, S_M10_LO,
    S_M0F_RD, S_M0F_BIT, S_HDR, S_C_PRE, S_C_BODY,
    S_W_RD, S_W_CAP, S_W_HI, S_W_LO, S_CLO, S_CHI
  } back_state_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[src/modbus_rtu_slave_engine.sv]
// Modbus RTU slave engine. Feed it received serial bytes (op=0) and
// one-second ticks (op=1) on the input channel. The front end hunts for a
// byte equal to slave_address, frames 8 bytes (or count+9 bytes for codes
// 0x0F and 0x10) into a 64-byte frame memory and hands each finished frame or
// tick to the back end through a two-entry job queue. The back end walks the
// frame once through a byte-wide CRC-16 (poly 0xA001), then executes codes
// 1-6, 0x0F and 0x10 against a 64-word holding memory (cleared by per-word
// valid bits) and a 20-byte coil store, and streams the reply bytes with the
// CRC appended on the fly; addresses 100-109 alias coil byte pairs. Bad CRC,
// unknown codes and oversized replies give no output. Each tick yields one
// status item carrying link_fault. A finished frame passes through the queue
// pop, CRC walk, check, dispatch and modulo-10000 reduction (one subtract
// per cycle). Writes update the stores before the header goes out; reads
// stream their data after it; the CRC bytes close the reply. Coil reads first
// prime the coil read; register reads step through read, capture, high and
// low states per word; code 0x0F fetches each data byte, then writes its coil
// bits one by one; code 0x10 reads each word from the frame, then writes it
// (twice when it aliases a coil pair). The pace is set by the single
// registered read ports of the frame and holding memories and by output
// back-pressure. The next item is taken once the job queue is empty and the
// back end has gone idle. No clearing pass is needed after reset.
module modbus_rtu_slave_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] tx_byte,
  output logic       last,
  output logic       link_fault
);
  import mrs_pkg::*;

  // configuration registers
  logic [7:0] slave_address;
  logic [7:0] fault_limit;

  // front end to frame memory
  logic                fr_we;
  logic [FRAME_AW-1:0] fr_waddr, fr_raddr;
  logic [7:0]          fr_wdata, fr_rdata;

  // job queue
  logic push, pop, q_valid, q_empty, back_idle;
  job_t push_job, q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      fault_limit   <= 8'd180;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDR:  slave_address <= cfg_data;
        CFG_FAULT_LIMIT: fault_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  mrs_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  mrs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .rx_byte       (rx_byte),
    .slave_address (slave_address),
    .fault_limit   (fault_limit),
    .q_empty       (q_empty),
    .back_idle     (back_idle),
    .fr_we         (fr_we),
    .fr_waddr      (fr_waddr),
    .fr_wdata      (fr_wdata),
    .push          (push),
    .push_job      (push_job)
  );

  mrs_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_empty  (q_empty),
    .q_job    (q_job)
  );

  mrs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .q_valid       (q_valid),
    .q_job         (q_job),
    .pop           (pop),
    .back_idle     (back_idle),
    .fr_raddr      (fr_raddr),
    .fr_rdata      (fr_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (kind),
    .out_byte      (tx_byte),
    .out_last      (last),
    .out_fault     (link_fault)
  );

endmodule

[src/mrs_ram.sv]
module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mrs_front.sv]
module mrs_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             slave_address,
  input  logic [7:0]             fault_limit,
  input  logic                   q_empty,
  input  logic                   back_idle,
  output logic                   fr_we,
  output logic [mrs_pkg::FRAME_AW-1:0] fr_waddr,
  output logic [7:0]             fr_wdata,
  output logic                   push,
  output mrs_pkg::job_t          push_job
);
  import mrs_pkg::*;

  logic [FLEN_W-1:0] count, count_next;
  logic [EXP_W-1:0]  exp_len, exp_len_next;
  logic              in_frame, in_frame_next;
  logic              known, known_next;
  logic [7:0]        tick_count, tick_count_next;
  logic              fault, fault_next;

  logic              accept;
  logic [8:0]        tick_inc;
  logic [FLEN_W-1:0] cnt1;
  logic [EXP_W-1:0]  exp_new;

  assign in_ready = q_empty && back_idle;
  assign accept   = in_valid && in_ready;
  assign fr_wdata = rx_byte;
  assign tick_inc = {1'b0, tick_count} + 9'd1;
  assign cnt1     = count + FLEN_W'(1);
  assign exp_new  = {1'b0, rx_byte} + EXP_W'(LEN_EXTRA);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      exp_len    <= '0;
      in_frame   <= 1'b0;
      known      <= 1'b0;
      tick_count <= '0;
      fault      <= 1'b0;
    end else begin
      count      <= count_next;
      exp_len    <= exp_len_next;
      in_frame   <= in_frame_next;
      known      <= known_next;
      tick_count <= tick_count_next;
      fault      <= fault_next;
    end
  end

  always_comb begin
    count_next      = count;
    exp_len_next    = exp_len;
    in_frame_next   = in_frame;
    known_next      = known;
    tick_count_next = tick_count;
    fault_next      = fault;
    fr_we           = 1'b0;
    fr_waddr        = count[FRAME_AW-1:0];
    push            = 1'b0;
    push_job        = '0;
    if (accept) begin
      if (op) begin
        if (tick_inc > {1'b0, fault_limit}) begin
          tick_count_next = '0;
          fault_next      = 1'b1;
        end else begin
          tick_count_next = tick_inc[7:0];
        end
        push           = 1'b1;
        push_job.tick  = 1'b1;
        push_job.fault = fault_next;
      end else if (!in_frame) begin
        // address hunt
        if (rx_byte == slave_address) begin
          fr_we         = 1'b1;
          fr_waddr      = '0;
          count_next    = FLEN_W'(1);
          in_frame_next = 1'b1;
          known_next    = 1'b0;
        end
      end else if (count >= FLEN_W'(FRAME_DEPTH)) begin
        in_frame_next = 1'b0;
      end else begin
        fr_we      = 1'b1;
        count_next = cnt1;
        if (!known) begin
          if (cnt1 == FLEN_W'(2) && rx_byte != FC_WRITE_REGS && rx_byte != FC_WRITE_COILS) begin
            exp_len_next = EXP_W'(FIXED_LEN);
            known_next   = 1'b1;
          end else if (cnt1 == FLEN_W'(FIRST_DATA)) begin
            exp_len_next = exp_new;
            known_next   = 1'b1;
            if (exp_new > EXP_W'(FRAME_DEPTH)) begin
              in_frame_next = 1'b0;
              known_next    = 1'b0;
            end
          end
        end else if ({{(EXP_W-FLEN_W){1'b0}}, cnt1} >= exp_len) begin
          in_frame_next   = 1'b0;
          known_next      = 1'b0;
          tick_count_next = '0;
          fault_next      = 1'b0;
          push            = 1'b1;
          push_job.flen   = exp_len[FLEN_W-1:0];
        end
      end
    end
  end

endmodule

[src/mrs_jobq.sv]
module mrs_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mrs_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_empty,
  output mrs_pkg::job_t q_job
);
  import mrs_pkg::*;

  localparam int QAW = $clog2(JOBQ_DEPTH);

  job_t                      entry [JOBQ_DEPTH];
  logic [QAW-1:0]            wptr, rptr;
  logic [$clog2(JOBQ_DEPTH+1)-1:0] fill;
  logic                      do_push, do_pop;

  assign q_valid = (fill != '0);
  assign q_empty = !q_valid;
  assign q_job   = entry[rptr];
  assign do_pop  = pop && q_valid;
  assign do_push = push && (fill != ($clog2(JOBQ_DEPTH+1))'(JOBQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QAW'(JOBQ_DEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QAW'(JOBQ_DEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_job;
    end
  end

endmodule

[src/mrs_back.sv]
module mrs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   slave_address,
  input  logic                         q_valid,
  input  mrs_pkg::job_t                q_job,
  output logic                         pop,
  output logic                         back_idle,
  output logic [mrs_pkg::FRAME_AW-1:0] fr_raddr,
  input  logic [7:0]                   fr_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         out_fault
);
  import mrs_pkg::*;

  back_state_t state, state_next;

  logic [FRAME_AW-1:0] ptr, ptr_next;
  logic [FLEN_W-1:0]   flen, flen_next;
  logic                jfault, jfault_next;
  logic [7:0]          code, code_next, ahi, ahi_next, alo, alo_next;
  logic [7:0]          nhi, nhi_next, nlo, nlo_next, cnt, cnt_next;
  logic [15:0]         got, got_next, crc, crc_next, addr, addr_next;
  logic [KC_W-1:0]     kc, kc_next, lim, lim_next;
  logic [7:0]          third, third_next;
  logic                echo, echo_next;
  logic [2:0]          hidx, hidx_next;
  logic [7:0]          whi, whi_next, wlo, wlo_next, cprev, cprev_next;
  logic [15:0]         word, word_next;
  logic [CIDX_W-1:0]   cidx, cidx_next;

  logic [7:0]          coil [COIL_BYTES];
  logic [HOLD_WORDS-1:0] hvalid;

  // coil store ports
  logic [CIDX_W-1:0]   crd_idx, cw_idx;
  logic [7:0]          coil_rd, cw_data;
  logic                cw_en;

  // holding store ports
  logic                hram_we;
  logic [HOLD_AW-1:0]  hram_waddr, hram_raddr;
  logic [15:0]         hram_wdata, hram_rdata;

  // output stage
  logic                can_emit, out_load, ok, ol;
  logic [7:0]          ob;

  logic [15:0]         num, aoff, bidx;
  logic [FLEN_W-1:0]   n_crc;
  logic                a_hold, a_map;
  logic [CIDX_W-1:0]   map_lo_idx, map_hi_idx;
  logic [13:0]         bc;
  logic [10:0]         bits_avail;
  logic [6:0]          words_avail;
  logic [KC_W:0]       pos10;
  logic [7:0]          hdr_byte, cbody, cmask;
  logic [15:0]         cw16;
  logic [2:0]          hlast;

  mrs_ram #(.WIDTH(16), .DEPTH(HOLD_WORDS)) u_hold (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (hram_wdata),
    .raddr (hram_raddr),
    .rdata (hram_rdata)
  );

  assign num        = {nhi, nlo};
  assign n_crc      = flen - FLEN_W'(2);
  assign a_hold     = addr < 16'(HOLD_WORDS);
  assign a_map      = (addr >= COIL_MAP_BASE) && (addr < COIL_MAP_END);
  assign aoff       = addr - COIL_MAP_BASE;
  assign map_lo_idx = {aoff[CIDX_W-2:0], 1'b0};
  assign map_hi_idx = {aoff[CIDX_W-2:0], 1'b1};
  assign bidx       = addr + {{(16-KC_W){1'b0}}, kc};
  assign bc         = 14'(({1'b0, num} + 17'd7) >> 3);
  assign bits_avail = {cnt, 3'b000};
  assign words_avail = cnt[7:1];
  assign pos10      = (KC_W+1)'(FIRST_DATA) + {kc, 1'b0};
  assign hlast      = echo ? HDR_LAST_ECHO : HDR_LAST_READ;
  assign coil_rd    = (crd_idx < CIDX_W'(COIL_BYTES)) ? coil[crd_idx[COIL_AW-1:0]] : 8'h00;
  assign cw16       = {coil_rd, cprev} >> addr[2:0];
  assign cmask      = (8'd1 << num[2:0]) - 8'd1;
  assign cbody      = (kc + KC_W'(1) == lim && num[2:0] != 3'd0) ? (cw16[7:0] & cmask)
                                                                : cw16[7:0];
  assign can_emit   = !out_valid || out_ready;
  assign back_idle  = (state == S_IDLE);
  assign hram_waddr = addr[HOLD_AW-1:0];
  assign hram_wdata = {whi, wlo};
  assign hram_raddr = addr[HOLD_AW-1:0];

  always_comb begin
    case (hidx)
      3'd0:    hdr_byte = slave_address;
      3'd1:    hdr_byte = code;
      3'd2:    hdr_byte = third;
      3'd3:    hdr_byte = alo;
      3'd4:    hdr_byte = nhi;
      default: hdr_byte = nlo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hvalid    <= '0;
      for (int i = 0; i < COIL_BYTES; i++) begin
        coil[i] <= 8'h00;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (hram_we) begin
        hvalid[hram_waddr] <= 1'b1;
      end
      if (cw_en && cw_idx < CIDX_W'(COIL_BYTES)) begin
        coil[cw_idx[COIL_AW-1:0]] <= cw_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;   flen <= flen_next;   jfault <= jfault_next;
    code <= code_next; ahi <= ahi_next;     alo <= alo_next;
    nhi <= nhi_next;   nlo <= nlo_next;     cnt <= cnt_next;
    got <= got_next;   crc <= crc_next;     addr <= addr_next;
    kc <= kc_next;     lim <= lim_next;     third <= third_next;
    echo <= echo_next; hidx <= hidx_next;   whi <= whi_next;
    wlo <= wlo_next;   word <= word_next;   cprev <= cprev_next;
    cidx <= cidx_next;
    if (out_load) begin
      out_kind  <= ok;
      out_byte  <= ob;
      out_last  <= ol;
      out_fault <= jfault;
    end
  end

  always_comb begin
    state_next = state;
    ptr_next = ptr;     flen_next = flen;   jfault_next = jfault;
    code_next = code;   ahi_next = ahi;     alo_next = alo;
    nhi_next = nhi;     nlo_next = nlo;     cnt_next = cnt;
    got_next = got;     crc_next = crc;     addr_next = addr;
    kc_next = kc;       lim_next = lim;     third_next = third;
    echo_next = echo;   hidx_next = hidx;   whi_next = whi;
    wlo_next = wlo;     word_next = word;   cprev_next = cprev;
    cidx_next = cidx;
    pop      = 1'b0;
    fr_raddr = ptr;
    crd_idx  = '0;
    cw_en    = 1'b0;
    cw_idx   = '0;
    cw_data  = 8'h00;
    hram_we  = 1'b0;
    out_load = 1'b0;
    ok       = 1'b0;
    ob       = 8'h00;
    ol       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop         = 1'b1;
          jfault_next = q_job.fault;
          flen_next   = q_job.flen;
          if (q_job.tick) begin
            state_next = S_STAT;
          end else begin
            fr_raddr   = '0;
            ptr_next   = '0;
            crc_next   = CRC_INIT;
            state_next = S_CRC;
          end
        end
      end
      S_STAT: begin
        if (can_emit) begin
          out_load   = 1'b1;
          ok         = 1'b1;
          ol         = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CRC: begin
        // walk the frame once: CRC over the body, capture header and check bytes
        if ({1'b0, ptr} < n_crc) begin
          crc_next = crc16_byte(crc, fr_rdata);
        end
        if ({1'b0, ptr} == n_crc) begin
          got_next[7:0] = fr_rdata;
        end
        if ({1'b0, ptr} == n_crc + FLEN_W'(1)) begin
          got_next[15:8] = fr_rdata;
        end
        case (ptr)
          FRAME_AW'(1): code_next = fr_rdata;
          FRAME_AW'(2): ahi_next  = fr_rdata;
          FRAME_AW'(3): alo_next  = fr_rdata;
          FRAME_AW'(4): nhi_next  = fr_rdata;
          FRAME_AW'(5): nlo_next  = fr_rdata;
          FRAME_AW'(6): cnt_next  = fr_rdata;
          default: ;
        endcase
        if ({1'b0, ptr} == flen - FLEN_W'(1)) begin
          state_next = S_CHECK;
        end else begin
          fr_raddr = ptr + FRAME_AW'(1);
          ptr_next = ptr + FRAME_AW'(1);
        end
      end
      S_CHECK: begin
        if (got != crc) begin
          state_next = S_IDLE;
        end else begin
          addr_next  = {ahi, alo};
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (addr >= REG_SPAN) begin
          addr_next = addr - REG_SPAN;
        end else begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        kc_next    = '0;
        echo_next  = 1'b1;
        third_next = ahi;
        unique case (code) inside
          FC_READ_COILS, FC_READ_INPUTS: begin
            echo_next  = 1'b0;
            third_next = bc[7:0];
            lim_next   = bc[KC_W-1:0];
            state_next = (bc > 14'(MAX_BC)) ? S_IDLE : S_HDR;
          end
          FC_READ_HOLD, FC_READ_INREG: begin
            echo_next  = 1'b0;
            third_next = {nlo[6:0], 1'b0};
            lim_next   = {{(KC_W-8){1'b0}}, nlo};
            state_next = (nlo > 8'(MAX_WORDS)) ? S_IDLE : S_HDR;
          end
          FC_WRITE_COIL: begin
            state_next = S_W5;
          end
          FC_WRITE_REG: begin
            whi_next   = nhi;
            wlo_next   = nlo;
            lim_next   = KC_W'(1);
            state_next = S_WW1;
          end
          FC_WRITE_COILS: begin
            lim_next   = (num > {5'b0, bits_avail}) ? bits_avail : num[KC_W-1:0];
            state_next = (num == 16'h0 || bits_avail == '0) ? S_HDR : S_M0F_RD;
          end
          FC_WRITE_REGS: begin
            lim_next   = (num > {9'b0, words_avail}) ? {4'b0, words_avail} : num[KC_W-1:0];
            state_next = (num == 16'h0 || words_avail == '0) ? S_HDR : S_M10_RD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_W5: begin
        crd_idx = addr[3+CIDX_W-1:3];
        cw_idx  = addr[3+CIDX_W-1:3];
        if (addr < FORCE_LIMIT && (num == COIL_ON || num == COIL_OFF)) begin
          cw_en   = 1'b1;
          cw_data = (num == COIL_ON) ? (coil_rd | (8'd1 << addr[2:0]))
                                     : (coil_rd & ~(8'd1 << addr[2:0]));
        end
        state_next = S_HDR;
      end
      S_WW1, S_WW2: begin
        logic done;
        done = 1'b1;
        if (state == S_WW1) begin
          if (a_hold) begin
            hram_we = 1'b1;
          end else if (a_map) begin
            cw_en   = 1'b1;
            cw_idx  = map_lo_idx;
            cw_data = wlo;
            done    = 1'b0;
          end
        end else begin
          cw_en   = 1'b1;
          cw_idx  = map_hi_idx;
          cw_data = whi;
        end
        if (!done) begin
          state_next = S_WW2;
        end else begin
          kc_next    = kc + KC_W'(1);
          addr_next  = addr + 16'd1;
          state_next = (kc + KC_W'(1) == lim) ? S_HDR : S_M10_RD;
        end
      end
      S_M10_RD: begin
        fr_raddr   = pos10[FRAME_AW-1:0];
        state_next = S_M10_HI;
      end
      S_M10_HI: begin
        whi_next   = fr_rdata;
        fr_raddr   = pos10[FRAME_AW-1:0] + FRAME_AW'(1);
        state_next = S_M10_LO;
      end
      S_M10_LO: begin
        wlo_next   = fr_rdata;
        state_next = S_WW1;
      end
      S_M0F_RD, S_M0F_BIT: begin
        fr_raddr = FRAME_AW'(FIRST_DATA) + kc[FRAME_AW+2:3];
        if (state == S_M0F_RD) begin
          state_next = S_M0F_BIT;
        end else begin
          crd_idx = bidx[3+CIDX_W-1:3];
          cw_idx  = bidx[3+CIDX_W-1:3];
          cw_en   = 1'b1;
          cw_data = fr_rdata[kc[2:0]] ? (coil_rd | (8'd1 << bidx[2:0]))
                                      : (coil_rd & ~(8'd1 << bidx[2:0]));
          kc_next = kc + KC_W'(1);
          if (kc + KC_W'(1) == lim) begin
            state_next = S_HDR;
          end else if (kc[2:0] == 3'd7) begin
            state_next = S_M0F_RD;
          end
        end
      end
      S_HDR: begin
        if (can_emit) begin
          out_load  = 1'b1;
          ob        = hdr_byte;
          crc_next  = crc16_byte(crc, hdr_byte);
          hidx_next = hidx + 3'd1;
          if (hidx == hlast) begin
            if (echo || lim == '0) begin
              state_next = S_CLO;
            end else if (code == FC_READ_COILS || code == FC_READ_INPUTS) begin
              state_next = S_C_PRE;
            end else begin
              state_next = S_W_RD;
            end
          end
        end
      end
      S_C_PRE: begin
        crd_idx    = addr[3+CIDX_W-1:3];
        cprev_next = coil_rd;
        cidx_next  = addr[3+CIDX_W-1:3] + CIDX_W'(1);
        state_next = S_C_BODY;
      end
      S_C_BODY: begin
        crd_idx = cidx;
        if (can_emit) begin
          out_load   = 1'b1;
          ob         = cbody;
          crc_next   = crc16_byte(crc, cbody);
          cprev_next = coil_rd;
          cidx_next  = cidx + CIDX_W'(1);
          kc_next    = kc + KC_W'(1);
          if (kc + KC_W'(1) == lim) begin
            state_next = S_CLO;
          end
        end
      end
      S_W_RD: begin
        crd_idx    = map_lo_idx;
        wlo_next   = coil_rd;
        state_next = S_W_CAP;
      end
      S_W_CAP: begin
        crd_idx = map_hi_idx;
        if (a_hold) begin
          word_next = hvalid[hram_raddr] ? hram_rdata : 16'h0;
        end else if (a_map) begin
          word_next = {coil_rd, wlo};
        end else begin
          word_next = 16'h0;
        end
        state_next = S_W_HI;
      end
      S_W_HI: begin
        if (can_emit) begin
          out_load   = 1'b1;
          ob         = word[15:8];
          crc_next   = crc16_byte(crc, word[15:8]);
          state_next = S_W_LO;
        end
      end
      S_W_LO: begin
        if (can_emit) begin
          out_load   = 1'b1;
          ob         = word[7:0];
          crc_next   = crc16_byte(crc, word[7:0]);
          addr_next  = addr + 16'd1;
          kc_next    = kc + KC_W'(1);
          state_next = (kc + KC_W'(1) == lim) ? S_CLO : S_W_RD;
        end
      end
      S_CLO: begin
        if (can_emit) begin
          out_load   = 1'b1;
          ob         = crc[7:0];
          state_next = S_CHI;
        end
      end
      S_CHI: begin
        if (can_emit) begin
          out_load   = 1'b1;
          ob         = crc[15:8];
          ol         = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // fresh reply CRC and header counter on entry to the header
    if (state != S_HDR && state_next == S_HDR) begin
      crc_next  = CRC_INIT;
      hidx_next = '0;
      kc_next   = '0;
    end
  end

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind) |-> (out_last && out_byte == 8'h00))
    else $error("status item without last or with data");

  a_crc_hi_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHI && can_emit) |=> (state == S_IDLE && out_valid && out_last))
    else $error("reply did not close after CRC high byte");

  a_hold_range: assert property (@(posedge clk) disable iff (rst)
    hram_we |-> (state == S_WW1 && addr < 16'(HOLD_WORDS)))
    else $error("holding write outside holding range");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE && q_valid))
    else $error("queue popped while busy");

endmodule

[test/tb_modbus_rtu_slave_engine.sv]
`timescale 1ns / 100ps

module tb_modbus_rtu_slave_engine;
  import mrs_pkg::*;

  // one output item as the block presents it
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       fault;
  } reply_t;

  // one input item: a serial byte or a tick
  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } rx_item_t;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       kind;
  logic [7:0] tx_byte;
  logic       last;
  logic       link_fault;

  modbus_rtu_slave_engine u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .tx_byte(tx_byte), .last(last), .link_fault(link_fault)
  );

  always #4 clk = ~clk;

  // stimulus and expectations
  rx_item_t   rx_pending[$];
  reply_t     reply_expect[$];
  int         errors = 0;
  bit         calm = 1'b0;   // no idling on either side while set
  int         queued = 0;

  // slave shadow: config, framing and stores
  logic [7:0]  sh_addr = 8'd1;
  logic [7:0]  sh_limit = 8'd180;
  logic [7:0]  sh_frame[FRAME_DEPTH];
  int          sh_count = 0;
  int          sh_explen = 0;
  bit          sh_in = 1'b0;
  bit          sh_known = 1'b0;
  logic [15:0] sh_hold[HOLD_WORDS];
  logic [7:0]  sh_coil[COIL_BYTES];
  int          sh_ticks = 0;
  bit          sh_fault = 1'b0;
  logic [7:0]  sh_tx[$];

  initial begin
    foreach (sh_hold[k]) sh_hold[k] = '0;
    foreach (sh_coil[k]) sh_coil[k] = '0;
  end

  function automatic logic [15:0] modbus_crc(input logic [7:0] q[$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (q[k]) begin
      c ^= {8'h00, q[k]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic int coil_rd(input int idx);
    return (idx < COIL_BYTES) ? int'(sh_coil[idx]) : 0;
  endfunction

  function automatic void coil_wr(input int idx, input int v);
    if (idx < COIL_BYTES) sh_coil[idx] = v[7:0];
  endfunction

  function automatic void word_wr(input int a, input int hi, input int lo);
    if (a < HOLD_WORDS) sh_hold[a] = {hi[7:0], lo[7:0]};
    else if (a >= 100 && a < 110) begin
      coil_wr((a - 100) * 2, lo);
      coil_wr((a - 100) * 2 + 1, hi);
    end
  endfunction

  function automatic void bit_wr(input int a, input int v);
    int j;
    j = a / 8;
    if (j < COIL_BYTES) sh_coil[j][a % 8] = v[0];
  endfunction

  // run a completed frame; fills sh_tx with the reply (no CRC), empty for none
  function automatic void serve_frame();
    logic [7:0] body[$];
    logic [7:0] code;
    int n, a, num, got, bc, i, j, w, v, lim;
    bit multi;
    sh_tx = {};
    code = sh_frame[1];
    multi = (code == FC_WRITE_REGS || code == FC_WRITE_COILS);
    n = multi ? int'(sh_frame[6]) + 7 : 6;
    for (int k = 0; k < n; k++) body.push_back(sh_frame[k]);
    got = {sh_frame[n + 1], sh_frame[n]};
    if (got != modbus_crc(body)) return;
    a = {sh_frame[2], sh_frame[3]} % 10000;
    num = {sh_frame[4], sh_frame[5]};
    sh_tx = '{sh_addr, code};
    case (code)
      FC_READ_COILS, FC_READ_INPUTS: begin
        bc = (num + 7) / 8;
        i = a % 8;
        j = a / 8;
        if (bc + 5 > REPLY_MAX) begin
          sh_tx = {};
          return;
        end
        sh_tx.push_back(bc[7:0]);
        for (int k = 0; k < bc; k++) begin
          w = coil_rd(j + k) | (coil_rd(j + k + 1) << 8);
          v = (w >> i) & 255;
          if (k + 1 == bc && num % 8 != 0) v &= (1 << (num % 8)) - 1;
          sh_tx.push_back(v[7:0]);
        end
        return;
      end
      FC_READ_HOLD, FC_READ_INREG: begin
        num = sh_frame[5];
        if (num * 2 + 5 > REPLY_MAX) begin
          sh_tx = {};
          return;
        end
        sh_tx.push_back(8'(num * 2));
        for (int k = 0; k < num; k++) begin
          w = 0;
          if (a + k < HOLD_WORDS) w = sh_hold[a + k];
          else if (a + k >= 100 && a + k < 110)
            w = (coil_rd((a + k - 100) * 2 + 1) << 8) | coil_rd((a + k - 100) * 2);
          sh_tx.push_back(w[15:8]);
          sh_tx.push_back(w[7:0]);
        end
        return;
      end
      FC_WRITE_COIL: begin
        if (a < 120) begin
          if (num == 16'hFF00) bit_wr(a, 1);
          else if (num == 0) bit_wr(a, 0);
        end
      end
      FC_WRITE_REG: word_wr(a, sh_frame[4], sh_frame[5]);
      FC_WRITE_COILS: begin
        lim = int'(sh_frame[6]) * 8;
        if (num > lim) num = lim;
        for (int k = 0; k < num; k++)
          bit_wr(a + k, (sh_frame[7 + k / 8] >> (k % 8)) & 1);
      end
      FC_WRITE_REGS: begin
        lim = int'(sh_frame[6]) / 2;
        if (num > lim) num = lim;
        for (int k = 0; k < num; k++)
          word_wr(a + k, sh_frame[7 + 2 * k], sh_frame[8 + 2 * k]);
      end
      default: begin
        sh_tx = {};
        return;
      end
    endcase
    for (int k = 2; k < 6; k++) sh_tx.push_back(sh_frame[k]);
  endfunction

  // advance the shadow by one accepted item and queue what it should produce
  function automatic void slave_step(input logic is_tick, input logic [7:0] b);
    int t;
    logic [15:0] c;
    if (is_tick) begin
      t = sh_ticks + 1;
      if (t > sh_limit) begin
        t = 0;
        sh_fault = 1'b1;
      end
      sh_ticks = t & 255;
      reply_expect.push_back('{1'b1, 8'h00, 1'b1, sh_fault});
      return;
    end
    if (!sh_in) begin
      if (b == sh_addr) begin
        sh_frame[0] = b;
        sh_count = 1;
        sh_in = 1'b1;
        sh_known = 1'b0;
      end
      return;
    end
    if (sh_count >= FRAME_DEPTH) begin
      sh_in = 1'b0;
      return;
    end
    sh_frame[sh_count++] = b;
    if (!sh_known) begin
      if (sh_count == 2 && b != FC_WRITE_REGS && b != FC_WRITE_COILS) begin
        sh_explen = FIXED_LEN;
        sh_known = 1'b1;
      end else if (sh_count == 7) begin
        sh_explen = int'(b) + LEN_EXTRA;
        sh_known = 1'b1;
        if (sh_explen > FRAME_DEPTH) begin
          sh_in = 1'b0;
          sh_known = 1'b0;
        end
      end
      return;
    end
    if (sh_count < sh_explen) return;
    sh_in = 1'b0;
    sh_known = 1'b0;
    sh_ticks = 0;
    sh_fault = 1'b0;
    serve_frame();
    if (sh_tx.size() == 0 || sh_tx.size() + 2 > REPLY_MAX) return;
    c = modbus_crc(sh_tx);
    sh_tx.push_back(c[7:0]);
    sh_tx.push_back(c[15:8]);
    foreach (sh_tx[k])
      reply_expect.push_back('{1'b0, sh_tx[k], (k == sh_tx.size() - 1), 1'b0});
  endfunction

  // driver: one item in flight, random gaps unless calm
  always @(posedge clk) begin : drive_p
    logic nv;
    rx_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        slave_step(op, rx_byte);
        nv = 1'b0;
      end
      if (!nv && rx_pending.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        it = rx_pending.pop_front();
        op <= it.op;
        rx_byte <= it.b;
        nv = 1'b1;
      end
      in_valid <= nv;
    end
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // monitor: random back-pressure, compare each reply item with the oldest expected
  always @(posedge clk) begin : watch_p
    reply_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_expect.size() == 0) begin
          report($sformatf("unexpected item kind=%0d byte=%h", kind, tx_byte));
        end else begin
          e = reply_expect.pop_front();
          if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
          if (tx_byte !== e.data) report($sformatf("tx_byte %h, want %h", tx_byte, e.data));
          if (last !== e.last) report($sformatf("last %0d, want %0d", last, e.last));
          if (link_fault !== e.fault)
            report($sformatf("link_fault %0d, want %0d", link_fault, e.fault));
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // watchdog: too long with no item moving on either side
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    rx_pending.push_back('{1'b0, b});
    queued++;
  endtask

  task automatic put_tick();
    rx_pending.push_back('{1'b1, $urandom_range(255)});
    queued++;
  endtask

  // frame with CRC appended; a corrupt frame gets a flipped CRC bit
  task automatic put_frame(input logic [7:0] body[$], input bit corrupt);
    logic [15:0] c;
    c = modbus_crc(body);
    if (corrupt) c ^= 16'(1 << $urandom_range(15));
    foreach (body[k]) put_byte(body[k]);
    put_byte(c[7:0]);
    put_byte(c[15:8]);
  endtask

  task automatic set_reg(input logic idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == CFG_SLAVE_ADDR) sh_addr = v;
    else sh_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_reg_addr();
    case ($urandom_range(4))
      0, 1: return 16'($urandom_range(70));
      2: return 16'($urandom_range(125, 95));
      3: return 16'(10000 * $urandom_range(6) + $urandom_range(130));
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed request with random content, sometimes corrupted or oversized
  task automatic rand_frame();
    logic [7:0] f[$];
    logic [7:0] codes[9];
    logic [7:0] code;
    logic [15:0] a, num;
    int cnt;
    codes = '{FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLD, FC_READ_INREG, FC_WRITE_COIL,
              FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS, 8'h00};
    code = codes[$urandom_range(8)];
    if (code == 8'h00) code = $urandom_range(255);
    a = pick_reg_addr();
    f = '{sh_addr, code, a[15:8], a[7:0]};
    case (code)
      FC_READ_COILS, FC_READ_INPUTS:
        num = ($urandom_range(5) == 0) ? 16'($urandom_range(600)) : 16'($urandom_range(40));
      FC_READ_HOLD, FC_READ_INREG:
        num = {8'($urandom), ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(32))};
      FC_WRITE_COIL:
        case ($urandom_range(2))
          0: num = 16'hFF00;
          1: num = 16'h0000;
          default: num = $urandom;
        endcase
      FC_WRITE_COILS, FC_WRITE_REGS: num = $urandom_range(30);
      default: num = $urandom;
    endcase
    f.push_back(num[15:8]);
    f.push_back(num[7:0]);
    if (code == FC_WRITE_COILS || code == FC_WRITE_REGS) begin
      cnt = ($urandom_range(9) == 0) ? $urandom_range(80, 50) : $urandom_range(12);
      f.push_back(cnt[7:0]);
      if (cnt + LEN_EXTRA <= FRAME_DEPTH)
        repeat (cnt) f.push_back($urandom);
    end
    if (f.size() >= 7 && f[6] + LEN_EXTRA > FRAME_DEPTH) begin
      // dropped at the count byte; what follows is hunted over
      foreach (f[k]) put_byte(f[k]);
    end else begin
      put_frame(f, $urandom_range(9) == 0);
    end
  endtask

  task automatic rand_phase(input int n);
    int stop;
    stop = queued + n;
    while (queued < stop) begin
      case ($urandom_range(19))
        0, 1, 2: put_tick();
        3, 4: put_byte($urandom);
        default: rand_frame();
      endcase
    end
  endtask

  // wait for the block to go quiet so config may change
  task automatic drain();
    while (rx_pending.size() > 0 || in_valid || reply_expect.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: fault after two ticks at limit 1, coil-pair write through the
    // register alias, read back above the 10000 wrap, noise while hunting
    set_reg(CFG_SLAVE_ADDR, 8'd1);
    set_reg(CFG_FAULT_LIMIT, 8'd1);
    put_tick();
    put_tick();
    put_byte(8'hFF);
    put_byte(8'h00);
    put_frame('{8'd1, FC_WRITE_REG, 8'h00, 8'h69, 8'hA5, 8'h5A}, 1'b0);
    put_frame('{8'd1, FC_READ_HOLD, 8'h27, 8'h79, 8'h00, 8'h02}, 1'b0);
    put_tick();
    drain();

    set_reg(CFG_SLAVE_ADDR, 8'd0);
    set_reg(CFG_FAULT_LIMIT, 8'd255);
    rand_phase(30);
    drain();

    // long stretch with no idling on either side
    calm = 1'b1;
    set_reg(CFG_SLAVE_ADDR, 8'd255);
    set_reg(CFG_FAULT_LIMIT, 8'd1);
    rand_phase(30);
    drain();
    calm = 1'b0;

    set_reg(CFG_SLAVE_ADDR, 8'($urandom));
    set_reg(CFG_FAULT_LIMIT, 8'($urandom_range(255, 1)));
    rand_phase(30);
    drain();

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
